// File: rtl/pinhole_point_projector_defines.svh
// Assertion macros for the pinhole point projector top level.
`ifndef PINHOLE_POINT_PROJECTOR_DEFINES_SVH
`define PINHOLE_POINT_PROJECTOR_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define PPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define PPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ppp_pkg.sv
// Shared constants, word types and register codes for the pinhole point projector.
`timescale 1ns / 1ps

package ppp_pkg;

    // Field widths fixed by the interface.
    localparam int FRAC_W     = 16;
    localparam int XY_W       = 32;
    localparam int FOCAL_W    = 16;
    localparam int SCALE_W    = 16;
    localparam int CENTER_W   = 12;
    localparam int DIM_CFG_W  = 13;
    localparam int COLOR_W    = 8;
    localparam int ADDR_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Largest frame dimension; rows and cols are clamped to it.
    localparam int MAX_DIM  = 4096;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = COORD_W + 1;

    // Numerator magnitude |x| * f * scale and denominator (f << 16) + z.
    localparam int FS_W     = FOCAL_W + SCALE_W;
    localparam int NUM_W    = XY_W - 1 + FS_W;
    localparam int DEN_W    = FOCAL_W + FRAC_W + 2;
    localparam int AD_W     = DEN_W - 1;

    // A quotient of 2^QSAT_W or more can never land inside the frame.
    localparam int QSAT_W   = ((COORD_W > CENTER_W) ? COORD_W : CENTER_W) + 1;
    localparam int Q_W      = QSAT_W + 1;
    localparam int DIV_W    = AD_W + QSAT_W;
    localparam int S_W      = QSAT_W + 2;

    // Address arithmetic width, wide enough for both the product and the port.
    localparam int PROD_W   = COORD_W + DIM_W;
    localparam int ADDR_X_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_U_CENTER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V_CENTER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_U_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V_SCALE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS   = 3'd6;

    // Register values after reset.
    localparam logic [FOCAL_W-1:0]   FOCAL_RST  = 16'd100;
    localparam logic [CENTER_W-1:0]  CENTER_RST = 12'd200;
    localparam logic [SCALE_W-1:0]   SCALE_RST  = 16'd100;
    localparam logic [DIM_CFG_W-1:0] DIM_RST    = 13'd400;

    // Input word: one colored point.
    typedef struct packed {
        logic signed [XY_W-1:0] point_x;
        logic signed [XY_W-1:0] point_y;
        logic signed [XY_W-1:0] point_z;
        logic [COLOR_W-1:0]     red_in;
        logic [COLOR_W-1:0]     green_in;
        logic [COLOR_W-1:0]     blue_in;
    } t_point_in;

    // Output word: one frame-buffer write.
    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
    } t_pixel_out;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

    // Word carried through the divider chain.
    typedef struct packed {
        logic [NUM_W-1:0] rem_u;
        logic [NUM_W-1:0] rem_v;
        logic [DIV_W-1:0] div;
        logic [Q_W-1:0]   q_u;
        logic [Q_W-1:0]   q_v;
        logic             neg_u;
        logic             neg_v;
        t_color           color;
    } t_div_bus;

    // Frame geometry seen by the back end.
    typedef struct packed {
        logic [CENTER_W-1:0] u_center;
        logic [CENTER_W-1:0] v_center;
        logic [DIM_W-1:0]    rows_eff;
        logic [DIM_W-1:0]    cols_eff;
    } t_geom;

endpackage

// File: rtl/ppp_front.sv
// Front end: magnitudes and denominator, then the numerator multiplies.
`timescale 1ns / 1ps

module ppp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  ppp_pkg::t_point_in           i_point,
    input  logic [ppp_pkg::FOCAL_W-1:0]  i_focal_length,
    input  logic [ppp_pkg::FS_W-1:0]     i_fs_u,
    input  logic [ppp_pkg::FS_W-1:0]     i_fs_v,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ppp_pkg::t_div_bus            o_bus
);
    import ppp_pkg::*;

    logic                    r_s1_valid;
    logic [XY_W-1:0]         r_s1_ax;
    logic [XY_W-1:0]         r_s1_ay;
    logic                    r_s1_xneg;
    logic                    r_s1_yneg;
    logic signed [DEN_W-1:0] r_s1_den;
    t_color                  r_s1_color;

    logic [XY_W-1:0]         n_s1_ax;
    logic [XY_W-1:0]         n_s1_ay;
    logic signed [DEN_W-1:0] n_s1_den;

    logic                    r_s2_valid;
    t_div_bus                r_s2_bus;
    t_div_bus                n_s2_bus;

    logic                    w_en1;
    logic                    w_en2;
    logic [DEN_W-1:0]        w_neg_den;
    logic [AD_W-1:0]         w_ad;
    logic [2*XY_W-1:0]       w_prod_u;
    logic [2*XY_W-1:0]       w_prod_v;

    // A stage loads when it is empty or its word moves on.
    assign w_en2   = !r_s2_valid || i_ready;
    assign w_en1   = !r_s1_valid || w_en2;
    assign o_ready = w_en1;

    // Stage 1: absolute coordinates and the signed denominator (f << 16) + z.
    always_comb begin
        n_s1_ax  = i_point.point_x[XY_W-1] ? -i_point.point_x : i_point.point_x;
        n_s1_ay  = i_point.point_y[XY_W-1] ? -i_point.point_y : i_point.point_y;
        n_s1_den = $signed({2'b00, i_focal_length, {FRAC_W{1'b0}}})
                 + DEN_W'(i_point.point_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_ax          <= n_s1_ax;
            r_s1_ay          <= n_s1_ay;
            r_s1_xneg        <= i_point.point_x[XY_W-1];
            r_s1_yneg        <= i_point.point_y[XY_W-1];
            r_s1_den         <= n_s1_den;
            r_s1_color.red   <= i_point.red_in;
            r_s1_color.green <= i_point.green_in;
            r_s1_color.blue  <= i_point.blue_in;
        end
    end

    // Stage 2: numerator magnitudes and the first divisor alignment.
    assign w_neg_den = -r_s1_den;
    assign w_ad      = r_s1_den[DEN_W-1] ? w_neg_den[AD_W-1:0] : r_s1_den[AD_W-1:0];
    assign w_prod_u  = r_s1_ax * i_fs_u;
    assign w_prod_v  = r_s1_ay * i_fs_v;

    always_comb begin
        n_s2_bus.rem_u = w_prod_u[NUM_W-1:0];
        n_s2_bus.rem_v = w_prod_v[NUM_W-1:0];
        n_s2_bus.div   = {w_ad, {QSAT_W{1'b0}}};
        n_s2_bus.q_u   = '0;
        n_s2_bus.q_v   = '0;
        n_s2_bus.neg_u = r_s1_xneg ^ r_s1_den[DEN_W-1];
        n_s2_bus.neg_v = r_s1_yneg ^ r_s1_den[DEN_W-1];
        n_s2_bus.color = r_s1_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_bus <= n_s2_bus;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_bus   = r_s2_bus;

endmodule

// File: rtl/ppp_div_step.sv
// One restoring division stage: one quotient bit for u and for v.
`timescale 1ns / 1ps

module ppp_div_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ppp_pkg::t_div_bus i_bus,
    output logic              o_valid,
    input  logic              i_ready,
    output ppp_pkg::t_div_bus o_bus
);
    import ppp_pkg::*;

    logic             r_valid;
    t_div_bus         r_bus;
    t_div_bus         n_bus;

    logic             w_en;
    logic [NUM_W-1:0] w_dext;
    logic             w_ge_u;
    logic             w_ge_v;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Trial subtract of the aligned divisor; the divisor then moves one bit down.
    assign w_dext = {{(NUM_W-DIV_W){1'b0}}, i_bus.div};
    assign w_ge_u = i_bus.rem_u >= w_dext;
    assign w_ge_v = i_bus.rem_v >= w_dext;

    always_comb begin
        n_bus       = i_bus;
        n_bus.rem_u = w_ge_u ? (i_bus.rem_u - w_dext) : i_bus.rem_u;
        n_bus.rem_v = w_ge_v ? (i_bus.rem_v - w_dext) : i_bus.rem_v;
        n_bus.q_u   = {i_bus.q_u[Q_W-2:0], w_ge_u};
        n_bus.q_v   = {i_bus.q_v[Q_W-2:0], w_ge_v};
        n_bus.div   = i_bus.div >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

// File: rtl/ppp_back.sv
// Back end: signed rounding, center offset and bounds test, then the pixel address.
`timescale 1ns / 1ps

module ppp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ppp_pkg::t_div_bus   i_bus,
    input  ppp_pkg::t_geom      i_geom,
    output logic                o_valid,
    input  logic                i_stall,
    output ppp_pkg::t_pixel_out o_pixel
);
    import ppp_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] value;
    } t_coord;

    // Truncated pixel coordinate from magnitude quotient, sign and offset.
    // The quotient is floored first, the offset added, and a negative inexact
    // sum stepped back up so the whole result truncates toward zero.
    function automatic t_coord f_coord(
        input logic [Q_W-1:0]      q,
        input logic                inexact,
        input logic                neg,
        input logic [CENTER_W-1:0] off,
        input logic [DIM_W-1:0]    lim
    );
        logic signed [S_W-1:0] qm;
        logic signed [S_W-1:0] bump;
        logic signed [S_W-1:0] fq;
        logic signed [S_W-1:0] s;
        logic signed [S_W-1:0] sa;
        logic signed [S_W-1:0] zero;
        t_coord                res;
        qm    = $signed({{(S_W-QSAT_W){1'b0}}, q[QSAT_W-1:0]});
        bump  = $signed({{(S_W-1){1'b0}}, inexact});
        zero  = '0;
        fq    = neg ? (-qm - bump) : qm;
        s     = fq + $signed({{(S_W-CENTER_W){1'b0}}, off});
        sa    = (s < zero) ? (s + bump) : s;
        // A set top quotient bit means the quotient saturated, which also
        // covers a zero denominator: the point cannot fall inside the frame.
        res.ok    = !q[Q_W-1] && (sa > zero)
                  && (sa < $signed({{(S_W-DIM_W){1'b0}}, lim}));
        res.value = sa[COORD_W-1:0];
        return res;
    endfunction

    logic               r_a_valid;
    logic [COORD_W-1:0] r_a_u;
    logic [COORD_W-1:0] r_a_v;
    t_color             r_a_color;

    logic               r_b_valid;
    t_pixel_out         r_b_pixel;
    t_pixel_out         n_b_pixel;

    logic               w_en_a;
    logic               w_en_b;
    t_coord             w_u;
    t_coord             w_v;
    logic [ADDR_X_W-1:0] w_addr;

    assign w_en_b  = !r_b_valid || !i_stall;
    assign w_en_a  = !r_a_valid || w_en_b;
    assign o_ready = w_en_a;

    // Stage A: both coordinates and the frame test; points outside are dropped.
    assign w_u = f_coord(i_bus.q_u, |i_bus.rem_u, i_bus.neg_u,
                         i_geom.u_center, i_geom.rows_eff);
    assign w_v = f_coord(i_bus.q_v, |i_bus.rem_v, i_bus.neg_v,
                         i_geom.v_center, i_geom.cols_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en_a) begin
            r_a_valid <= i_valid && w_u.ok && w_v.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_u     <= w_u.value;
            r_a_v     <= w_v.value;
            r_a_color <= i_bus.color;
        end
    end

    // Stage B: row-major address u * cols + v; this register is the output.
    assign w_addr = ADDR_X_W'(r_a_u) * ADDR_X_W'(i_geom.cols_eff) + ADDR_X_W'(r_a_v);

    always_comb begin
        n_b_pixel.pixel_address = w_addr[ADDR_W-1:0];
        n_b_pixel.red_out       = r_a_color.red;
        n_b_pixel.green_out     = r_a_color.green;
        n_b_pixel.blue_out      = r_a_color.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_pixel <= n_b_pixel;
        end
    end

    assign o_valid = r_b_valid;
    assign o_pixel = r_b_pixel;

endmodule

// File: rtl/pinhole_point_projector.sv
// Pinhole point projector top level: camera registers, front end, divider chain, back end.
// An accepted point passes the front end, one divider stage per quotient bit and the back end to its word.
// Throughput: one point per cycle while the output does not stall; restoring divider, one quotient bit a stage.
// Points outside the frame leave no word; every stage holds its word under output stall.
// Reset: synchronous, active low; clears all valid bits and loads the default camera registers.
`timescale 1ns / 1ps

`include "pinhole_point_projector_defines.svh"

module pinhole_point_projector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  ppp_pkg::t_point_in             i_point,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ppp_pkg::t_pixel_out            o_pixel,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ppp_pkg::*;

    logic [FOCAL_W-1:0]   r_focal_length;
    logic [CENTER_W-1:0]  r_u_center;
    logic [CENTER_W-1:0]  r_v_center;
    logic [SCALE_W-1:0]   r_u_scale;
    logic [SCALE_W-1:0]   r_v_scale;
    logic [DIM_CFG_W-1:0] r_frame_rows;
    logic [DIM_CFG_W-1:0] r_frame_cols;
    logic [FS_W-1:0]      r_fs_u;
    logic [FS_W-1:0]      r_fs_v;

    logic                 w_front_ready;
    t_geom                w_geom;
    logic                 w_dvalid [0:Q_W];
    logic                 w_dready [0:Q_W];
    t_div_bus             w_dbus   [0:Q_W];

    // Camera registers; the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_length <= FOCAL_RST;
            r_u_center     <= CENTER_RST;
            r_v_center     <= CENTER_RST;
            r_u_scale      <= SCALE_RST;
            r_v_scale      <= SCALE_RST;
            r_frame_rows   <= DIM_RST;
            r_frame_cols   <= DIM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FOCAL_LENGTH: r_focal_length <= i_cfg_data[FOCAL_W-1:0];
                CFG_U_CENTER:     r_u_center     <= i_cfg_data[CENTER_W-1:0];
                CFG_V_CENTER:     r_v_center     <= i_cfg_data[CENTER_W-1:0];
                CFG_U_SCALE:      r_u_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_V_SCALE:      r_v_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_FRAME_ROWS:   r_frame_rows   <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_FRAME_COLS:   r_frame_cols   <= i_cfg_data[DIM_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Focal length times scale, registered and reformed continuously from the camera registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_u <= FOCAL_RST * SCALE_RST;
            r_fs_v <= FOCAL_RST * SCALE_RST;
        end else begin
            r_fs_u <= r_focal_length * r_u_scale;
            r_fs_v <= r_focal_length * r_v_scale;
        end
    end

    // Frame bounds clamped to the largest supported dimension.
    always_comb begin
        w_geom.u_center = r_u_center;
        w_geom.v_center = r_v_center;
        w_geom.rows_eff = (r_frame_rows > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_frame_rows);
        w_geom.cols_eff = (r_frame_cols > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_frame_cols);
    end

    assign o_stall = !w_front_ready;

    ppp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (w_front_ready),
        .i_point        (i_point),
        .i_focal_length (r_focal_length),
        .i_fs_u         (r_fs_u),
        .i_fs_v         (r_fs_v),
        .o_valid        (w_dvalid[0]),
        .i_ready        (w_dready[0]),
        .o_bus          (w_dbus[0])
    );

    // Divider chain: one stage per quotient bit, most significant first.
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        ppp_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dvalid[k]),
            .o_ready (w_dready[k]),
            .i_bus   (w_dbus[k]),
            .o_valid (w_dvalid[k+1]),
            .i_ready (w_dready[k+1]),
            .o_bus   (w_dbus[k+1])
        );
    end

    ppp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dvalid[Q_W]),
        .o_ready (w_dready[Q_W]),
        .i_bus   (w_dbus[Q_W]),
        .i_geom  (w_geom),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

    // An empty output register leaves every stage free to load.
    `PPP_ASSERT_NOW(a_no_stall_when_out_empty, i_clk, i_rst_n, !o_valid, !o_stall, "input stalled while the output register is empty")
    // A quotient held at the end of the divider is not lost while the back end is full.
    `PPP_ASSERT_NEXT(a_div_tail_holds, i_clk, i_rst_n, w_dvalid[Q_W] && !w_dready[Q_W], w_dvalid[Q_W], "divider tail word lost under stall")

endmodule
